// ===== hdl/apw_pkg.sv =====
// apw_pkg: widths, constants, stage map and helpers shared by the
// attenuation projection / weight pipeline. No dependencies.
package apw_pkg;

    localparam int BIN_W      = 24;
    localparam int PROJ_W     = 16;
    localparam int WEIGHT_W   = 28;
    localparam int FRAC_W     = 32;
    localparam int LOG_W      = 37;
    localparam int DIFF_W     = 31;
    localparam int NUM_W      = 64;
    localparam int DIVN_W     = 66;
    localparam int DIVD_W     = 38;

    // log2: one normalize stage and one squaring stage per fraction bit
    localparam int LOG_STAGES = FRAC_W + 1;
    // divider: one range check stage and one stage per quotient bit
    localparam int DIV_STEPS  = WEIGHT_W;
    localparam int DIV_STAGES = DIV_STEPS + 1;

    // stage map of the top level, stage 0 is the input register
    localparam int ST_LOG_OUT = LOG_STAGES;
    localparam int ST_DIFF    = ST_LOG_OUT + 1;
    localparam int ST_PROD    = ST_DIFF + 1;
    localparam int ST_PROJ    = ST_PROD + 1;
    localparam int ST_EB      = ST_PROJ + 1;
    localparam int ST_PART    = ST_EB + 1;
    localparam int ST_NUM     = ST_PART + 1;
    localparam int ST_PREP    = ST_NUM + 1;
    localparam int ST_OUT     = ST_PREP + DIV_STAGES;
    localparam int N_STAGES   = ST_OUT + 1;

    localparam logic [BIN_W-1:0]    ONE_Q8     = 24'd256;
    localparam logic [31:0]         LN2_Q32    = 32'd2977044472;
    localparam logic [PROJ_W-1:0]   FLOOR_RST  = 16'd61440;
    localparam logic [PROJ_W-1:0]   PROJ_MAX   = 16'hFFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 28'hFFFFFFF;

    typedef struct packed {
        logic [BIN_W-1:0]  b;
        logic [BIN_W-1:0]  t;
        logic              last;
        logic [PROJ_W-1:0] proj;
    } t_side;

    function automatic logic [4:0] msb_index(input logic [BIN_W-1:0] x);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < BIN_W; i++) begin
            if (x[i]) begin
                n = 5'(i);
            end
        end
        return n;
    endfunction

endpackage

// ===== hdl/apw_bin_if.sv =====
// apw_bin_if: input channel carrying one sinogram bin per transfer.
// Depends on apw_pkg for field widths.
interface apw_bin_if;
    logic                       valid;
    logic                       ready;
    logic [apw_pkg::BIN_W-1:0]  blank_count;
    logic [apw_pkg::BIN_W-1:0]  tx_count;
    logic                       last_in;

    modport source(output valid, blank_count, tx_count, last_in, input ready);
    modport sink(input valid, blank_count, tx_count, last_in, output ready);
endinterface

// ===== hdl/apw_res_if.sv =====
// apw_res_if: output channel carrying projection, weight and clamped values.
// Depends on apw_pkg for field widths.
interface apw_res_if;
    logic                          valid;
    logic                          ready;
    logic [apw_pkg::PROJ_W-1:0]    line_integral;
    logic [apw_pkg::WEIGHT_W-1:0]  stat_weight;
    logic [apw_pkg::BIN_W-1:0]     blank_clamped;
    logic [apw_pkg::BIN_W-1:0]     tx_clamped;
    logic                          last_out;

    modport source(output valid, line_integral, stat_weight, blank_clamped,
                   tx_clamped, last_out, input ready);
    modport sink(input valid, line_integral, stat_weight, blank_clamped,
                 tx_clamped, last_out, output ready);
endinterface

// ===== hdl/apw_log2.sv =====
// apw_log2: pipelined log2 in Q.32, normalize then one squaring per bit.
// Depends on apw_pkg.
module apw_log2 (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [apw_pkg::BIN_W-1:0] i_x,
    output logic [apw_pkg::LOG_W-1:0] o_log
);
    import apw_pkg::*;

    logic [31:0]       r_m [0:FRAC_W];
    logic [FRAC_W-1:0] r_f [0:FRAC_W];
    logic [4:0]        r_n [0:FRAC_W];
    logic [4:0]        n_idx;

    assign n_idx = msb_index(i_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= {8'b0, i_x} << (5'd31 - n_idx);
            r_f[0] <= '0;
            r_n[0] <= n_idx;
        end
    end

    for (genvar k = 1; k <= FRAC_W; k++) begin : g_sq
        logic [63:0] n_sq;
        logic [32:0] n_top;
        logic [31:0] n_m;

        always_comb begin
            n_sq  = r_m[k-1] * r_m[k-1];
            n_top = n_sq[63:31];
            // mantissa reached two: halve it and emit a one
            n_m   = n_top[32] ? n_top[32:1] : n_top[31:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k] <= n_m;
                r_f[k] <= {r_f[k-1][FRAC_W-2:0], n_top[32]};
                r_n[k] <= r_n[k-1];
            end
        end
    end

    assign o_log = {r_n[FRAC_W], r_f[FRAC_W]};
endmodule

// ===== hdl/apw_div.sv =====
// apw_div: pipelined restoring divider, one quotient bit per stage,
// saturating at the weight maximum. Depends on apw_pkg.
module apw_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [apw_pkg::DIVN_W-1:0]   i_num,
    input  logic [apw_pkg::DIVD_W-1:0]   i_den,
    output logic [apw_pkg::WEIGHT_W-1:0] o_quot
);
    import apw_pkg::*;

    logic [DIVN_W-1:0]   r_rem [0:DIV_STEPS];
    logic [DIVD_W-1:0]   r_den [0:DIV_STEPS];
    logic [WEIGHT_W-1:0] r_q   [0:DIV_STEPS];
    logic                r_ovf [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= (i_num >= {i_den, {DIV_STEPS{1'b0}}});
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [DIVN_W-1:0] n_sub;
        logic              n_bit;

        always_comb begin
            n_sub = {{(DIVN_W-DIVD_W){1'b0}}, r_den[k-1]} << (DIV_STEPS - k);
            n_bit = (r_rem[k-1] >= n_sub);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_bit ? r_rem[k-1] - n_sub : r_rem[k-1];
                r_den[k] <= r_den[k-1];
                r_q[k]   <= {r_q[k-1][WEIGHT_W-2:0], n_bit};
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quot = r_ovf[DIV_STEPS] ? WEIGHT_MAX : r_q[DIV_STEPS];
endmodule

// ===== hdl/attenuation_projection_weight.sv =====
// attenuation_projection_weight: top level of the per-bin projection and
// weight pipeline. Depends on apw_pkg, apw_bin_if, apw_res_if, apw_log2
// and apw_div.
//
// Usage:
//   i_bin carries blank and transmission values (Q16.8) and a last flag.
//   o_res returns the projection ln(blank/tx) in Q4.12, the weight in
//   Q20.8, both clamped inputs and the last flag, one result per bin.
//   i_cfg_we / i_cfg_wdata write the weight floor (Q4.12), 15.0 at reset;
//   write it only while no bin is in flight.
//   Throughput: one bin per cycle unless the receiver stalls. Depth:
//   70 register stages; the two 33-stage log2 squaring pipes and the
//   29-stage divider set that depth.
//   Reset clears every valid bit and restores the floor; no clearing pass.
//   When the receiver stalls the whole pipeline holds and i_bin.ready
//   drops in the same cycle, so nothing is lost or repeated.
module attenuation_projection_weight (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [apw_pkg::PROJ_W-1:0] i_cfg_wdata,
    apw_bin_if.sink                    i_bin,
    apw_res_if.source                  o_res
);
    import apw_pkg::*;

    logic                r_v    [0:ST_OUT];
    t_side               r_side [0:ST_OUT];
    logic [PROJ_W-1:0]   r_floor;
    logic                en;

    logic [BIN_W-1:0]    n_b;
    logic [BIN_W-1:0]    n_t;
    logic [LOG_W-1:0]    log_b;
    logic [LOG_W-1:0]    log_t;

    logic [DIFF_W-1:0]   r_d;
    logic                r_pos;
    logic [62:0]         r_p;
    logic                r_pos2;
    logic [63:0]         n_rnd;
    logic [PROJ_W-1:0]   n_proj;
    logic [PROJ_W-1:0]   n_e;
    logic [39:0]         r_eb;
    logic [43:0]         r_nlo;
    logic [43:0]         r_nhi;
    logic [NUM_W-1:0]    r_num;
    logic [BIN_W:0]      n_sum;
    logic [DIVN_W-1:0]   r_nn;
    logic [DIVD_W-1:0]   r_dd;
    logic [WEIGHT_W-1:0] quot;

    assign en          = !r_v[ST_OUT] || o_res.ready;
    assign i_bin.ready = en;

    assign n_b = (i_bin.blank_count < ONE_Q8) ? ONE_Q8 : i_bin.blank_count;
    assign n_t = (i_bin.tx_count < ONE_Q8) ? ONE_Q8 : i_bin.tx_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= FLOOR_RST;
        end else if (i_cfg_we) begin
            r_floor <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ST_OUT; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_bin.valid;
            for (int k = 1; k <= ST_OUT; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= '{b: n_b, t: n_t, last: i_bin.last_in, proj: '0};
            for (int k = 1; k <= ST_OUT; k++) begin
                if (k == ST_PROJ) begin
                    r_side[k] <= '{b: r_side[k-1].b, t: r_side[k-1].t,
                                   last: r_side[k-1].last, proj: n_proj};
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    apw_log2 u_log_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_side[0].b),
        .o_log (log_b)
    );

    apw_log2 u_log_t (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_side[0].t),
        .o_log (log_t)
    );

    always_comb begin
        // round to nearest Q4.12, saturate
        n_rnd  = {1'b0, r_p} + 64'(64'd1 << 45);
        n_proj = '0;
        if (r_pos2) begin
            n_proj = (n_rnd[63:46] > 18'(PROJ_MAX)) ? PROJ_MAX : n_rnd[61:46];
        end
        n_e   = (r_side[ST_PROJ].proj > r_floor) ? r_side[ST_PROJ].proj : r_floor;
        n_sum = {1'b0, r_side[ST_NUM].b} + {1'b0, r_side[ST_NUM].t};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos  <= (log_b > log_t);
            r_d    <= DIFF_W'((log_b - log_t) >> 6);
            r_p    <= {32'b0, r_d} * {31'b0, LN2_Q32};
            r_pos2 <= r_pos;
            r_eb   <= {24'b0, n_e} * {16'b0, r_side[ST_PROJ].b};
            // e*b*t split in two halves of e*b
            r_nlo  <= {24'b0, r_eb[19:0]} * {20'b0, r_side[ST_EB].t};
            r_nhi  <= {24'b0, r_eb[39:20]} * {20'b0, r_side[ST_EB].t};
            r_num  <= {r_nhi, 20'b0} + {20'b0, r_nlo};
            // rounded quotient as floor((2*num + div) / (2*div))
            r_nn   <= {1'b0, r_num, 1'b0} + {28'b0, n_sum, 13'b0} - {29'b0, n_sum, 12'b0};
            r_dd   <= {n_sum, 13'b0};
        end
    end

    apw_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_nn),
        .i_den  (r_dd),
        .o_quot (quot)
    );

    assign o_res.valid         = r_v[ST_OUT];
    assign o_res.line_integral = r_side[ST_OUT].proj;
    assign o_res.stat_weight   = quot;
    assign o_res.blank_clamped = r_side[ST_OUT].b;
    assign o_res.tx_clamped    = r_side[ST_OUT].t;
    assign o_res.last_out      = r_side[ST_OUT].last;
endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for attenuation_projection_weight.
// Depends on apw_pkg, apw_bin_if, apw_res_if and the block's RTL.
module tb_top;
    import apw_pkg::*;

    typedef struct packed {
        logic [PROJ_W-1:0]   proj;
        logic [WEIGHT_W-1:0] weight;
        logic [BIN_W-1:0]    b;
        logic [BIN_W-1:0]    t;
        logic                last;
    } t_bin_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [PROJ_W-1:0] cfg_wdata = '0;

    apw_bin_if bin_ch ();
    apw_res_if res_ch ();

    attenuation_projection_weight dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_bin       (bin_ch.sink),
        .o_res       (res_ch.source)
    );

    always #1 i_clk = ~i_clk;

    logic [PROJ_W-1:0] floor_q412 = FLOOR_RST;
    t_bin_result       expected_bins[$];
    int                mismatch_cnt = 0;
    bit                rx_enable = 1'b0;

    function automatic logic [63:0] log2_q32(input logic [BIN_W-1:0] x);
        int          n;
        logic [63:0] m;
        logic [31:0] frac;
        n = 0;
        frac = '0;
        for (int i = 0; i < BIN_W; i++) if (x[i]) n = i;
        m = 64'(x) << (31 - n);
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(n) << 32) + 64'(frac);
    endfunction

    function automatic t_bin_result predict_bin(input logic [BIN_W-1:0] bc,
                                                input logic [BIN_W-1:0] tc,
                                                input logic lst);
        t_bin_result r;
        logic [63:0] lb, lt, d, p, prj, e, num, dv, q, rm;
        logic [BIN_W-1:0] b, t;
        b = (bc < ONE_Q8) ? ONE_Q8 : bc;
        t = (tc < ONE_Q8) ? ONE_Q8 : tc;
        lb = log2_q32(b);
        lt = log2_q32(t);
        prj = 0;
        if (lb > lt) begin
            d = (lb - lt) >> 6;
            p = d * 64'(LN2_Q32);
            prj = (p + (64'd1 << 45)) >> 46;
            if (prj > 64'hFFFF) prj = 64'hFFFF;
        end
        e = (prj > 64'(floor_q412)) ? prj : 64'(floor_q412);
        num = e * 64'(b) * 64'(t);
        dv = (64'(b) + 64'(t)) << 12;
        q = num / dv;
        rm = num % dv;
        if (rm * 2 >= dv) q = q + 1;
        if (q > 64'(WEIGHT_MAX)) q = 64'(WEIGHT_MAX);
        r.proj = prj[PROJ_W-1:0];
        r.weight = q[WEIGHT_W-1:0];
        r.b = b;
        r.t = t;
        r.last = lst;
        return r;
    endfunction

    task automatic send_bin(input logic [BIN_W-1:0] bc, input logic [BIN_W-1:0] tc,
                            input logic lst);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            bin_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        bin_ch.valid       <= 1'b1;
        bin_ch.blank_count <= bc;
        bin_ch.tx_count    <= tc;
        bin_ch.last_in     <= lst;
        @(posedge i_clk);
        while (!bin_ch.ready) @(posedge i_clk);
        expected_bins.push_back(predict_bin(bc, tc, lst));
    endtask

    task automatic drain_results;
        bin_ch.valid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_floor(input logic [PROJ_W-1:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        floor_q412 = v;
    endtask

    // result checker with random receiver stalls
    always @(posedge i_clk) begin
        t_bin_result got;
        if (rx_enable && res_ch.valid && res_ch.ready) begin
            got = {res_ch.line_integral, res_ch.stat_weight, res_ch.blank_clamped,
                   res_ch.tx_clamped, res_ch.last_out};
            if (expected_bins.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected transfer %h", got);
            end else begin
                if (got !== expected_bins[0]) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp proj %h wt %h b %h t %h l %b got %h %h %h %h %b",
                                 expected_bins[0].proj, expected_bins[0].weight,
                                 expected_bins[0].b, expected_bins[0].t,
                                 expected_bins[0].last, got.proj, got.weight,
                                 got.b, got.t, got.last);
                end
                void'(expected_bins.pop_front());
            end
        end
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!rx_enable) begin
            res_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if (!res_ch.ready || res_ch.valid) begin
            if (!res_ch.ready || $urandom_range(0, 2) == 0) begin
                // draw a new stall; zero leaves ready high
                stall_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 7);
            end
            res_ch.ready <= 1'b1;
        end
    end

    task automatic test_directed;
        send_bin(24'h0, 24'h0, 1'b0);
        send_bin(24'hFFFFFF, 24'h0, 1'b1);
        send_bin(24'h0, 24'hFFFFFF, 1'b0);
        send_bin(24'hFFFFFF, 24'hFFFFFF, 1'b1);
        send_bin(24'hFF, 24'h100, 1'b0);
        send_bin(24'h100, 24'h101, 1'b0);
        send_bin(24'h101, 24'h100, 1'b1);
        send_bin(24'h800000, 24'h100, 1'b0);
        send_bin(24'h123456, 24'h123456, 1'b0);
        send_bin(24'hFFFFFF, 24'h100, 1'b1);
        send_bin(24'hAAAAAA, 24'h555555, 1'b0);
        send_bin(24'h555555, 24'hAAAAAA, 1'b1);
    endtask

    function automatic logic [BIN_W-1:0] rand_bin;
        case ($urandom_range(0, 4))
            0: return BIN_W'($urandom_range(0, 511));
            1: return 24'hFFFFFF - BIN_W'($urandom_range(0, 255));
            2: return BIN_W'($urandom) >> $urandom_range(0, 23);
            default: return BIN_W'($urandom);
        endcase
    endfunction

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_bin(rand_bin(), rand_bin(), 1'($urandom));
    endtask

    task automatic test_floor_settings;
        write_floor(16'h0000);
        send_bin(24'h100, 24'h100, 1'b0);
        send_bin(24'h1000, 24'h1000, 1'b1);
        test_random(300);
        write_floor(16'hFFFF);
        send_bin(24'hFFFFFF, 24'hFFFFFF, 1'b0);
        test_random(300);
        write_floor(16'($urandom));
        test_random(300);
        write_floor(FLOOR_RST);
    endtask

    initial begin
        bin_ch.valid       = 1'b0;
        bin_ch.blank_count = '0;
        bin_ch.tx_count    = '0;
        bin_ch.last_in     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        rx_enable <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(500);
        // hold off the sender until the pipeline is empty
        bin_ch.valid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge i_clk);
        test_random(100);
        test_floor_settings();
        test_random(400);
        drain_results();
        if (mismatch_cnt == 0 && expected_bins.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
